### sv/sfdx_pkg.sv
package sfdx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned StatW  = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // Byte count saturates here; later bytes repeat this index.
  localparam logic [CountW-1:0] CountLimit = 10'd1023;

  // Frame layout offsets
  localparam logic [CountW-1:0] XorStartOff = 10'd2;
  localparam logic [CountW-1:0] LenOff      = 10'd4;
  localparam logic [CountW-1:0] CheckOff    = 10'd5;
  localparam logic [CountW-1:0] FrameExtra  = 10'd8;

  localparam logic [ByteW-1:0] HeaderOff   = 8'h00;
  localparam logic [ByteW-1:0] EndOff      = 8'hFF;

  localparam logic [ByteW-1:0]  HeaderRst  = 8'h00;
  localparam logic [ByteW-1:0]  EndRst     = 8'hFF;
  localparam logic [CountW-1:0] MaxLenRst  = 10'd263;

  typedef enum logic [StatW-1:0] {
    ST_COLLECT = 3'd0,
    ST_OK      = 3'd1,
    ST_HDR_BAD = 3'd2,
    ST_END_BAD = 3'd3,
    ST_XOR_BAD = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_HEADER  = 2'd0,
    REG_END     = 2'd1,
    REG_MAX_LEN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0]  header_byte;
    logic [ByteW-1:0]  stop_byte;
    logic [CountW-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] byte_index;
    logic [CountW-1:0] frame_length;
  } result_t;

endpackage

### sv/sfdx_in_if.sv
interface sfdx_in_if;
  logic                        valid;
  logic                        ready;
  logic [sfdx_pkg::ByteW-1:0]  rx_byte;
  logic                        chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

### sv/sfdx_out_if.sv
interface sfdx_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfdx_pkg::StatW-1:0]  status;
  logic [sfdx_pkg::ByteW-1:0]  byte_out;
  logic [sfdx_pkg::CountW-1:0] byte_index;
  logic [sfdx_pkg::CountW-1:0] frame_length;

  modport source (output valid, output status, output byte_out, output byte_index,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input byte_out, input byte_index,
                  input frame_length, output ready);
endinterface

### sv/sfdx_apb_regs.sv
module sfdx_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfdx_pkg::AddrW-1:0]  paddr,
  input  logic [sfdx_pkg::DataW-1:0]  pwdata,
  output logic [sfdx_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output sfdx_pkg::cfg_t              cfg_o
);
  import sfdx_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HEADER:  cfg_d.header_byte   = pwdata[ByteW-1:0];
        REG_END:     cfg_d.stop_byte     = pwdata[ByteW-1:0];
        REG_MAX_LEN: cfg_d.max_frame_len = pwdata[CountW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HEADER:  prdata = {{(DataW-ByteW){1'b0}}, cfg_q.header_byte};
      REG_END:     prdata = {{(DataW-ByteW){1'b0}}, cfg_q.stop_byte};
      REG_MAX_LEN: prdata = {{(DataW-CountW){1'b0}}, cfg_q.max_frame_len};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte   <= HeaderRst;
      cfg_q.stop_byte     <= EndRst;
      cfg_q.max_frame_len <= MaxLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/sfdx_parse.sv
module sfdx_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [sfdx_pkg::ByteW-1:0]  byte_i,
  input  logic                        last_i,
  input  sfdx_pkg::cfg_t              cfg_i,
  output sfdx_pkg::result_t           res_o
);
  import sfdx_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  chk_q, chk_d;
  logic              seen_q, seen_d;

  logic              fresh, hdr_bad, xor_hit, cap, done;
  logic [CountW-1:0] len_after, len_ext;
  status_e           status;

  always_comb begin
    fresh     = count_q < CountLimit;
    len_after = fresh ? count_q + 10'd1 : CountLimit;
    hdr_bad   = (count_q == '0) && (cfg_i.header_byte != HeaderOff) &&
                (byte_i != cfg_i.header_byte);

    // Length byte is taken first; the XOR window and check capture see it.
    len_d   = (fresh && count_q == LenOff) ? byte_i : len_q;
    len_ext = {{(CountW-ByteW){1'b0}}, len_d};

    xor_hit = fresh && (count_q >= XorStartOff) &&
              ((count_q <= LenOff) || (count_q <= len_ext + LenOff));
    xor_d   = xor_hit ? (xor_q ^ byte_i) : xor_q;

    cap     = fresh && (count_q >= CheckOff) && (count_q == len_ext + CheckOff) && !seen_q;
    chk_d   = cap ? byte_i : chk_q;
    seen_d  = seen_q || cap;

    done    = last_i && ((len_after >= cfg_i.max_frame_len) ||
                         (len_after >= len_ext + FrameExtra));

    if (hdr_bad) begin
      status = ST_HDR_BAD;
    end else if (done) begin
      if ((cfg_i.stop_byte != EndOff) && (byte_i != cfg_i.stop_byte)) begin
        status = ST_END_BAD;
      end else if (seen_d && (xor_d == chk_d)) begin
        status = ST_OK;
      end else begin
        status = ST_XOR_BAD;
      end
    end else begin
      status = ST_COLLECT;
    end

    // Any final status restarts the frame.
    count_d = (status == ST_COLLECT) ? len_after : '0;
  end

  assign res_o.status       = status;
  assign res_o.byte_index   = count_q;
  assign res_o.frame_length = len_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      len_q   <= '0;
      chk_q   <= '0;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      if (status == ST_COLLECT) begin
        xor_q  <= xor_d;
        len_q  <= len_d;
        chk_q  <= chk_d;
        seen_q <= seen_d;
      end else begin
        xor_q  <= '0;
        len_q  <= '0;
        chk_q  <= '0;
        seen_q <= 1'b0;
      end
    end
  end

endmodule

### sv/serial_frame_deframer_xor.sv
// Path: an input transfer reaches its result on out_o through the input register,
//   then the parse logic into the result register.
// Throughput: 1 byte per cycle while out_o.ready holds; the frame state updates as
//   each byte leaves the input register, so consecutive bytes flow without bubbles.
// Reset: rst_ni clears the frame state and both pipeline valids at once; the
//   registers return to header 0x00, end byte 0xFF and max frame length 263.
module serial_frame_deframer_xor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sfdx_in_if.sink                     in_i,
  sfdx_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfdx_pkg::AddrW-1:0]  paddr,
  input  logic [sfdx_pkg::DataW-1:0]  pwdata,
  output logic [sfdx_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import sfdx_pkg::*;

  cfg_t    cfg;
  result_t res;

  // Input register stage
  logic             in_v_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // Result register stage
  logic              out_v_q;
  status_e           out_status_q;
  logic [ByteW-1:0]  out_byte_q;
  logic [CountW-1:0] out_index_q;
  logic [CountW-1:0] out_len_q;

  logic advance;
  logic in_xfer;

  // Advance the held byte into the result register whenever that register is
  // empty or its content is being taken in this cycle.
  assign advance    = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  sfdx_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Frame state lives here and steps once per byte that advances.
  sfdx_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_xfer) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_i.rx_byte;
      in_last_q <= in_i.chunk_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // Hold the result while the sink stalls.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= res.status;
      out_byte_q   <= in_byte_q;
      out_index_q  <= res.byte_index;
      out_len_q    <= res.frame_length;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.status       = out_status_q;
  assign out_o.byte_out     = out_byte_q;
  assign out_o.byte_index   = out_index_q;
  assign out_o.frame_length = out_len_q;

endmodule

### sv/sfdx_checker.sv
module sfdx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sfdx_pkg::StatW-1:0]  out_status_i,
  input logic [sfdx_pkg::ByteW-1:0]  out_byte_i,
  input logic [sfdx_pkg::CountW-1:0] out_index_i,
  input logic [sfdx_pkg::CountW-1:0] out_length_i
);
  import sfdx_pkg::*;

  // A stalled transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
                                    $stable(out_byte_i) && $stable(out_index_i) &&
                                    $stable(out_length_i))
    else $error("result changed while stalled");

  // A header failure only happens on the first byte of a frame.
  a_hdr_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_HDR_BAD) |-> out_index_i == '0)
    else $error("header failure away from frame start");

  // Length counts this byte unless the count has saturated.
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_index_i != CountLimit) |-> out_length_i == out_index_i + 10'd1)
    else $error("frame length does not follow byte index");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_index_i == CountLimit) |-> out_length_i == CountLimit)
    else $error("saturated count moved");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == ST_COLLECT) || (out_status_i == ST_OK) ||
                    (out_status_i == ST_HDR_BAD) || (out_status_i == ST_END_BAD) ||
                    (out_status_i == ST_XOR_BAD))
    else $error("undefined status code");

endmodule

bind serial_frame_deframer_xor sfdx_checker u_sfdx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_byte_i   (out_o.byte_out),
  .out_index_i  (out_o.byte_index),
  .out_length_i (out_o.frame_length)
);
